// ----- design/esc_pkg.sv -----
// ---------------------------------------------------------------------------
// esc_pkg
// Shared types, register map and arithmetic helpers for the environmental
// sensor compensation block.
// ---------------------------------------------------------------------------
package esc_pkg;

  typedef logic signed [31:0] w32_t;

  // Register map (index = paddr[5:3])
  localparam logic [2:0] REG_TEMP    = 3'd0;
  localparam logic [2:0] REG_PRESS_A = 3'd1;
  localparam logic [2:0] REG_PRESS_B = 3'd2;
  localparam logic [2:0] REG_PRESS_C = 3'd3;
  localparam logic [2:0] REG_HUM     = 3'd4;

  localparam int ADDR_W = 6;

  // Result limits
  localparam w32_t TEMP_MIN  = -32'sd4000;
  localparam w32_t TEMP_MAX  = 32'sd8500;
  localparam logic [31:0] PRESS_MIN = 32'd30000;
  localparam logic [31:0] PRESS_MAX = 32'd110000;
  localparam w32_t HUM_Q22_MAX = 32'sd419430400;
  localparam logic [16:0] HUM_MAX = 17'd102400;

  // Work item passed from the front section to the back section
  typedef struct packed {
    logic signed [14:0] temp;
    logic [16:0]        hum;
    logic [31:0]        num;
    logic [31:0]        den;
    logic               big;
    logic               zero;
  } esc_job_t;

  // Result fields that travel beside the divider
  typedef struct packed {
    logic signed [14:0] temp;
    logic [16:0]        hum;
    logic               big;
    logic               zero;
  } esc_meta_t;

  // Signed divide by 2^k, truncating toward zero
  function automatic w32_t sdiv(input w32_t x, input int unsigned k);
    w32_t bias;
    bias = x[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
    return (x + bias) >>> k;
  endfunction

  function automatic w32_t sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

// ----- design/esc_in_if.sv -----
// ---------------------------------------------------------------------------
// esc_in_if
// Channel carrying one triple of raw converter readings per beat.
// ---------------------------------------------------------------------------
interface esc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_pressure;
  logic [19:0] raw_temperature;
  logic [15:0] raw_humidity;

  modport source (output valid, raw_pressure, raw_temperature, raw_humidity, input ready);
  modport sink   (input valid, raw_pressure, raw_temperature, raw_humidity, output ready);
endinterface

// ----- design/esc_out_if.sv -----
// ---------------------------------------------------------------------------
// esc_out_if
// Channel carrying one compensated result per beat.
// ---------------------------------------------------------------------------
interface esc_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] temperature_centi;
  logic [16:0]        pressure_pa;
  logic [16:0]        humidity_q10;

  modport source (output valid, temperature_centi, pressure_pa, humidity_q10, input ready);
  modport sink   (input valid, temperature_centi, pressure_pa, humidity_q10, output ready);
endinterface

// ----- design/esc_regs.sv -----
// ---------------------------------------------------------------------------
// esc_regs
// APB calibration register file, five coefficient words.
// ---------------------------------------------------------------------------
module esc_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [esc_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]               pwdata,
  output logic [63:0]               prdata,
  output logic                      pready,
  output logic [47:0]               temp_coeffs,
  output logic [47:0]               press_a,
  output logic [47:0]               press_b,
  output logic [47:0]               press_c,
  output logic [63:0]               hum_coeffs
);
  import esc_pkg::*;

  logic [47:0] temp_r, pa_r, pb_r, pc_r;
  logic [63:0] hum_r;
  logic [2:0]  idx;
  logic        wr;

  assign idx    = paddr[5:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write the addressed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_r <= '0;
      pa_r   <= '0;
      pb_r   <= '0;
      pc_r   <= '0;
      hum_r  <= '0;
    end else if (wr) begin
      case (idx)
        REG_TEMP:    temp_r <= pwdata[47:0];
        REG_PRESS_A: pa_r   <= pwdata[47:0];
        REG_PRESS_B: pb_r   <= pwdata[47:0];
        REG_PRESS_C: pc_r   <= pwdata[47:0];
        REG_HUM:     hum_r  <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_TEMP:    prdata = {16'd0, temp_r};
      REG_PRESS_A: prdata = {16'd0, pa_r};
      REG_PRESS_B: prdata = {16'd0, pb_r};
      REG_PRESS_C: prdata = {16'd0, pc_r};
      REG_HUM:     prdata = hum_r;
      default:     prdata = '0;
    endcase
  end

  assign temp_coeffs = temp_r;
  assign press_a     = pa_r;
  assign press_b     = pb_r;
  assign press_c     = pc_r;
  assign hum_coeffs  = hum_r;
endmodule

// ----- design/esc_front.sv -----
// ---------------------------------------------------------------------------
// esc_front
// Fifteen-stage free-running pipeline: fine temperature, temperature result,
// pressure dividend and divisor, and the full humidity result.
// ---------------------------------------------------------------------------
module esc_front (
  input  logic               clk,
  input  logic               rst_n,
  esc_in_if.sink             in_ch,
  input  logic               slot_free,
  input  logic [47:0]        temp_coeffs,
  input  logic [47:0]        press_a,
  input  logic [47:0]        press_b,
  input  logic [63:0]        hum_coeffs,
  output logic               accept,
  output logic               push,
  output esc_pkg::esc_job_t  job
);
  import esc_pkg::*;

  localparam int NST = 15;

  // Coefficients
  w32_t t1, t2, t3, p1, p2, p3, p4, p5, p6, h1, h2, h3, h4, h5, h6;
  assign t1 = {16'd0, temp_coeffs[15:0]};
  assign t2 = sx16(temp_coeffs[31:16]);
  assign t3 = sx16(temp_coeffs[47:32]);
  assign p1 = {16'd0, press_a[15:0]};
  assign p2 = sx16(press_a[31:16]);
  assign p3 = sx16(press_a[47:32]);
  assign p4 = sx16(press_b[15:0]);
  assign p5 = sx16(press_b[31:16]);
  assign p6 = sx16(press_b[47:32]);
  assign h1 = {24'd0, hum_coeffs[7:0]};
  assign h2 = sx16(hum_coeffs[23:8]);
  assign h3 = {24'd0, hum_coeffs[31:24]};
  assign h4 = {20'd0, hum_coeffs[43:32]};
  assign h5 = {20'd0, hum_coeffs[55:44]};
  assign h6 = {{24{hum_coeffs[63]}}, hum_coeffs[63:56]};

  assign in_ch.ready = slot_free;
  assign accept      = in_ch.valid && slot_free;

  logic [NST-1:0] vld_r;

  // Advance the valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NST-2:0], accept};
    end
  end

  // Pipeline payload
  logic [19:0]        ap_r [1:8];
  logic [15:0]        ah_r [1:5];
  logic signed [14:0] tc_r [5:15];
  w32_t               hv5_r [7:11];
  w32_t               hv3_r [12:14];
  logic [31:0]        num_r [10:15];
  logic [31:0]        den_r [10:15];
  logic               big_r [10:15];
  logic               zero_r [10:15];

  w32_t ta0_r, tb0_r, tam_r, tbb_r, ta_r, tbm_r, tf_r;
  w32_t pv1_r, pq_r, hv1_r;
  w32_t qq_r, v15_r, v4m_r, ha_r, hb_r, hm5_r, hadc_r;
  w32_t v2a_r, v3m_r, ha2_r, hb2_r, v15x2_r, v4_r;
  w32_t v2_r, v1b_r, hprod_r;
  w32_t v1m_r, hv4_r;
  logic [31:0] pn_r;
  w32_t hx_r, ha3_r, hq2_r, hv4b_r;
  logic [16:0] hum_r;

  // Stage-local combinational terms
  w32_t tfull, tq, pv1, adct;
  w32_t pnw, dn, hv5f, hq;
  logic [31:0] pn_prod;

  always_comb begin
    adct    = {12'd0, in_ch.raw_temperature};
    tfull   = sdiv((tf_r <<< 2) + tf_r + 32'sd128, 8);
    pv1     = sdiv(tf_r, 1) - 32'sd64000;
    pnw     = 32'sd1048576 - w32_t'({12'd0, ap_r[8]}) - sdiv(v2_r, 12);
    pn_prod = pnw * 32'd3125;
    dn      = sdiv(v1m_r, 15);
    hq      = sdiv(hv3_r[12], 15);
    hv5f    = hv3_r[14] - sdiv(hv4b_r, 4);
    tq      = TEMP_MIN;
    if (tfull > TEMP_MAX) begin
      tq = TEMP_MAX;
    end else if (tfull >= TEMP_MIN) begin
      tq = tfull;
    end
  end

  always_ff @(posedge clk) begin
    // Stage 1: capture and temperature offsets
    ap_r[1] <= in_ch.raw_pressure;
    ah_r[1] <= in_ch.raw_humidity;
    ta0_r   <= (adct >>> 3) - (t1 <<< 1);
    tb0_r   <= (adct >>> 4) - t1;
    for (int i = 2; i <= 8; i++) ap_r[i] <= ap_r[i-1];
    for (int i = 2; i <= 5; i++) ah_r[i] <= ah_r[i-1];
    // Stages 2-4: fine temperature
    tam_r <= ta0_r * t2;
    tbb_r <= tb0_r * tb0_r;
    ta_r  <= sdiv(tam_r, 11);
    tbm_r <= sdiv(tbb_r, 12) * t3;
    tf_r  <= ta_r + sdiv(tbm_r, 14);
    // Stage 5: temperature result, pressure and humidity offsets
    tc_r[5] <= tq[14:0];
    for (int i = 6; i <= 15; i++) tc_r[i] <= tc_r[i-1];
    pv1_r <= pv1;
    pq_r  <= sdiv(pv1, 2);
    hv1_r <= tf_r - 32'sd76800;
    // Stage 6: first products
    qq_r   <= pq_r * pq_r;
    v15_r  <= pv1_r * p5;
    v4m_r  <= p2 * pv1_r;
    ha_r   <= hv1_r * h6;
    hb_r   <= hv1_r * h3;
    hm5_r  <= h5 * hv1_r;
    hadc_r <= (w32_t'({16'd0, ah_r[5]}) <<< 14) - (h4 <<< 20);
    // Stage 7
    v2a_r    <= sdiv(qq_r, 11) * p6;
    v3m_r    <= p3 * sdiv(qq_r, 13);
    hv5_r[7] <= sdiv(hadc_r - hm5_r + 32'sd16384, 15);
    for (int i = 8; i <= 11; i++) hv5_r[i] <= hv5_r[i-1];
    ha2_r    <= sdiv(ha_r, 10);
    hb2_r    <= sdiv(hb_r, 11) + 32'sd32768;
    v15x2_r  <= v15_r <<< 1;
    v4_r     <= sdiv(v4m_r, 1);
    // Stage 8
    v2_r    <= sdiv(v2a_r + v15x2_r, 2) + (p4 <<< 16);
    v1b_r   <= sdiv(sdiv(v3m_r, 3) + v4_r, 18);
    hprod_r <= ha2_r * hb2_r;
    // Stage 9
    v1m_r <= (32'sd32768 + v1b_r) * p1;
    pn_r  <= pn_prod;
    hv4_r <= sdiv(hprod_r, 10) + 32'sd2097152;
    // Stage 10: divider operands
    den_r[10]  <= dn;
    zero_r[10] <= (dn == 32'sd0);
    big_r[10]  <= pn_r[31];
    num_r[10]  <= pn_r[31] ? pn_r : {pn_r[30:0], 1'b0};
    for (int i = 11; i <= 15; i++) begin
      den_r[i]  <= den_r[i-1];
      zero_r[i] <= zero_r[i-1];
      big_r[i]  <= big_r[i-1];
      num_r[i]  <= num_r[i-1];
    end
    hx_r <= hv4_r * h2;
    // Stages 11-15: humidity tail
    ha3_r     <= sdiv(hx_r + 32'sd8192, 14);
    hv3_r[12] <= hv5_r[11] * ha3_r;
    hv3_r[13] <= hv3_r[12];
    hv3_r[14] <= hv3_r[13];
    hq2_r     <= hq * hq;
    hv4b_r    <= sdiv(hq2_r, 7) * h1;
    if (hv5f[31]) begin
      hum_r <= '0;
    end else if (hv5f > HUM_Q22_MAX) begin
      hum_r <= HUM_MAX;
    end else begin
      hum_r <= hv5f[28:12];
    end
  end

  assign push      = vld_r[NST-1];
  assign job.temp  = tc_r[15];
  assign job.hum   = hum_r;
  assign job.num   = num_r[15];
  assign job.den   = den_r[15];
  assign job.big   = big_r[15];
  assign job.zero  = zero_r[15];
endmodule

// ----- design/esc_queue.sv -----
// ---------------------------------------------------------------------------
// esc_queue
// Job queue between front and back with a registered head entry and credit
// tracking, so the front never overruns it.
// ---------------------------------------------------------------------------
module esc_queue #(
  parameter int DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              reserve,
  input  logic              push,
  input  esc_pkg::esc_job_t wr_job,
  input  logic              pop,
  output logic              empty,
  output esc_pkg::esc_job_t rd_job,
  output logic              slot_free
);
  import esc_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  esc_job_t      mem [DEPTH];
  esc_job_t      head_r;
  logic          hv_r;
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r, cred_r;
  logic          load;

  // Refill the head entry when it is free or leaving
  assign load      = (!hv_r || pop) && (cnt_r != '0);
  assign empty     = !hv_r;
  assign slot_free = (cred_r < CW'(DEPTH));
  assign rd_job    = head_r;

  // Store pushed jobs and fetch the next one into the head register
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wr_job;
    end
    if (load) begin
      head_r <= mem[rp_r];
    end
  end

  // Track pointers, fill, head valid and credits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      cnt_r  <= '0;
      cred_r <= '0;
      hv_r   <= 1'b0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (load) rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r  <= cnt_r + CW'(push) - CW'(load);
      cred_r <= cred_r + CW'(reserve) - CW'(pop);
      if (load) begin
        hv_r <= 1'b1;
      end else if (pop) begin
        hv_r <= 1'b0;
      end
    end
  end
endmodule

// ----- design/esc_back.sv -----
// ---------------------------------------------------------------------------
// esc_back
// Pressure back end: 32-step restoring divider, pressure correction terms,
// clamping and the output register. Stalls as a whole on the output side.
// ---------------------------------------------------------------------------
module esc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              empty,
  input  esc_pkg::esc_job_t job,
  output logic              pop,
  input  logic [47:0]       press_c,
  esc_out_if.source         out_ch
);
  import esc_pkg::*;

  localparam int NDIV = 32;

  w32_t p7, p8, p9;
  assign p7 = sx16(press_c[15:0]);
  assign p8 = sx16(press_c[31:16]);
  assign p9 = sx16(press_c[47:32]);

  logic en;
  logic ov_r;
  assign en  = !ov_r || out_ch.ready;
  assign pop = en && !empty;

  logic [NDIV:0] dv_r;
  logic [31:0]   rem_r [0:NDIV];
  logic [31:0]   nm_r  [0:NDIV];
  logic [31:0]   qo_r  [0:NDIV];
  logic [31:0]   dn_r  [0:NDIV];
  esc_meta_t     mt_r  [0:NDIV];

  logic [31:0] rem_nxt [1:NDIV];
  logic        qb_nxt  [1:NDIV];

  // One quotient bit per stage
  always_comb begin
    logic [32:0] trial;
    for (int k = 1; k <= NDIV; k++) begin
      trial = {rem_r[k-1], nm_r[k-1][31]};
      qb_nxt[k] = (trial >= {1'b0, dn_r[k-1]});
      rem_nxt[k] = qb_nxt[k] ? 32'(trial - {1'b0, dn_r[k-1]}) : trial[31:0];
    end
  end

  logic [4:1]  pv_r;
  logic [31:0] pq1_r, e1_r, pq2_r, sq2_r, pq3_r;
  w32_t        w2m2_r, w1m3_r, w23_r;
  logic [31:0] r4_r;
  esc_meta_t   m1_r, m2_r, m3_r, m4_r;

  logic [31:0] qfin, pres;
  w32_t        r4;
  assign qfin = mt_r[NDIV].big ? {qo_r[NDIV][30:0], 1'b0} : qo_r[NDIV];
  assign r4   = w32_t'(pq3_r) + sdiv(sdiv(w1m3_r, 12) + w23_r + p7, 4);

  // Clamp the final pressure; a zero divisor gives the minimum
  always_comb begin
    if (m4_r.zero || r4_r < PRESS_MIN) begin
      pres = PRESS_MIN;
    end else if (r4_r > PRESS_MAX) begin
      pres = PRESS_MAX;
    end else begin
      pres = r4_r;
    end
  end

  // Hold valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
      pv_r <= '0;
      ov_r <= 1'b0;
    end else if (en) begin
      dv_r <= {dv_r[NDIV-1:0], !empty};
      pv_r <= {pv_r[3:1], dv_r[NDIV]};
      ov_r <= pv_r[4];
    end
  end

  logic signed [14:0] ot_r;
  logic [16:0]        op_r, oh_r;

  // Advance payload on enable
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      nm_r[0]  <= job.num;
      qo_r[0]  <= '0;
      dn_r[0]  <= job.den;
      mt_r[0]  <= '{temp: job.temp, hum: job.hum, big: job.big, zero: job.zero};
      for (int k = 1; k <= NDIV; k++) begin
        rem_r[k] <= rem_nxt[k];
        nm_r[k]  <= {nm_r[k-1][30:0], 1'b0};
        qo_r[k]  <= {qo_r[k-1][30:0], qb_nxt[k]};
        dn_r[k]  <= dn_r[k-1];
        mt_r[k]  <= mt_r[k-1];
      end
      // Pressure correction terms
      pq1_r  <= qfin;
      e1_r   <= {3'd0, qfin[31:3]};
      m1_r   <= mt_r[NDIV];
      pq2_r  <= pq1_r;
      sq2_r  <= e1_r * e1_r;
      w2m2_r <= w32_t'({2'd0, pq1_r[31:2]}) * p8;
      m2_r   <= m1_r;
      pq3_r  <= pq2_r;
      w1m3_r <= p9 * w32_t'({13'd0, sq2_r[31:13]});
      w23_r  <= sdiv(w2m2_r, 13);
      m3_r   <= m2_r;
      r4_r   <= r4;
      m4_r   <= m3_r;
      // Output register
      ot_r <= m4_r.temp;
      oh_r <= m4_r.hum;
      op_r <= pres[16:0];
    end
  end

  assign out_ch.valid             = ov_r;
  assign out_ch.temperature_centi = ot_r;
  assign out_ch.pressure_pa       = op_r;
  assign out_ch.humidity_q10      = oh_r;
endmodule

// ----- design/env_sensor_compensation.sv -----
// ---------------------------------------------------------------------------
// env_sensor_compensation
// Temperature, pressure and humidity compensation of raw sensor readings.
// ---------------------------------------------------------------------------
// Input channel in_ch carries one raw triple per beat; out_ch returns one
// compensated result (temperature 0.01 degC, pressure Pa, humidity Q10 %RH)
// per beat, in order. Calibration words are written over the APB port at
// byte address 8*i; write them only while no item is in flight.
// Throughput: one item per cycle sustained while out_ch is ready.
// Path: the front pipeline (fine temperature and humidity multiply chain),
// the job queue (store, then the head register), the bit-per-stage pressure
// divider, 4 correction stages and the output register.
// The queue holds QUEUE_DEPTH jobs; the front section reserves a slot when
// it accepts a beat, so in_ch.ready drops once QUEUE_DEPTH items are in the
// front pipeline and queue together.
// When out_ch stalls, the back section freezes and the queue absorbs the
// front's work in flight. Reset empties the pipeline and queue and clears all
// calibration registers to zero.
// ---------------------------------------------------------------------------
module env_sensor_compensation #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  esc_in_if.sink                     in_ch,
  esc_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [esc_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);
  import esc_pkg::*;

  logic [47:0] temp_coeffs, press_a, press_b, press_c;
  logic [63:0] hum_coeffs;
  logic        accept, push, pop, empty, slot_free;
  esc_job_t    wr_job, rd_job;

  esc_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .temp_coeffs, .press_a, .press_b, .press_c, .hum_coeffs
  );

  esc_front u_front (
    .clk, .rst_n, .in_ch, .slot_free, .temp_coeffs, .press_a, .press_b,
    .hum_coeffs, .accept, .push, .job(wr_job)
  );

  esc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .reserve(accept), .push, .wr_job, .pop, .empty, .rd_job,
    .slot_free
  );

  esc_back u_back (
    .clk, .rst_n, .empty, .job(rd_job), .pop, .press_c, .out_ch
  );
endmodule

// ----- test/tb_env_sensor_compensation.sv -----
// ---------------------------------------------------------------------------
// Environmental sensor compensation testbench
// Drives raw temperature/pressure/humidity triples through the block under
// several calibration sets, predicts each compensated result with a 32-bit
// wrapping integer model and checks every output beat in order.
// ---------------------------------------------------------------------------
class comp_scoreboard;
  typedef struct packed {
    logic signed [14:0] temp;
    logic [16:0]        press;
    logic [16:0]        hum;
  } comp_result_t;

  logic [63:0]  calib [5];
  comp_result_t pending_q[$];
  int           errors;

  function new();
    foreach (calib[i]) calib[i] = '0;
    errors = 0;
  endfunction

  static function int sext16(logic [15:0] v);
    return int'(signed'(v));
  endfunction

  // Hold fine temperature; return clamped temperature
  function int calc_temp(int adc, output int tfine);
    int t1, t2, t3, a, b, t;
    t1 = int'(calib[0][15:0]);
    t2 = sext16(calib[0][31:16]);
    t3 = sext16(calib[0][47:32]);
    a = (adc / 8) - t1 * 2;
    a = (a * t2) / 2048;
    b = (adc / 16) - t1;
    b = (((b * b) / 4096) * t3) / 16384;
    tfine = a + b;
    t = (tfine * 5 + 128) / 256;
    if (t < -4000) t = -4000;
    else if (t > 8500) t = 8500;
    return t;
  endfunction

  function int unsigned calc_press(int adc, int tf);
    int p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, v3, v4, q, w1, w2, r;
    int unsigned p, d, e, sq;
    p1 = int'(calib[1][15:0]);
    p2 = sext16(calib[1][31:16]);
    p3 = sext16(calib[1][47:32]);
    p4 = sext16(calib[2][15:0]);
    p5 = sext16(calib[2][31:16]);
    p6 = sext16(calib[2][47:32]);
    p7 = sext16(calib[3][15:0]);
    p8 = sext16(calib[3][31:16]);
    p9 = sext16(calib[3][47:32]);
    v1 = tf / 2 - 64000;
    q = v1 / 4;
    v2 = ((q * q) / 2048) * p6;
    v2 = v2 + (v1 * p5) * 2;
    v2 = v2 / 4 + p4 * 65536;
    v3 = (p3 * ((q * q) / 8192)) / 8;
    v4 = (p2 * v1) / 2;
    v1 = (v3 + v4) / 262144;
    v1 = ((32768 + v1) * p1) / 32768;
    if (v1 == 0) return 30000;
    p = 32'd1048576 - adc;
    p = (p - int'(v2 / 4096)) * 32'd3125;
    d = v1;
    if (p < 32'h8000_0000) p = (p << 1) / d;
    else p = (p / d) * 2;
    e = p / 8;
    sq = e * e;
    w1 = (p9 * int'(sq / 8192)) / 4096;
    w2 = (int'(p / 4) * p8) / 8192;
    r = int'(p) + (w1 + w2 + p7) / 16;
    p = r;
    if (p < 30000) p = 30000;
    else if (p > 110000) p = 110000;
    return p;
  endfunction

  function int unsigned calc_hum(int adc, int tf);
    int h1, h2, h3, h4, h5, h6, v1, v5, a, b, v4, v3, q;
    h1 = int'(calib[4][7:0]);
    h2 = sext16(calib[4][23:8]);
    h3 = int'(calib[4][31:24]);
    h4 = int'(calib[4][43:32]);
    h5 = int'(calib[4][55:44]);
    h6 = int'(signed'(calib[4][63:56]));
    v1 = tf - 76800;
    a = adc * 16384;
    b = h4 * 1048576;
    v5 = (a - b - h5 * v1 + 16384) / 32768;
    a = (v1 * h6) / 1024;
    b = (v1 * h3) / 2048;
    v4 = (a * (b + 32768)) / 1024 + 2097152;
    a = (v4 * h2 + 8192) / 16384;
    v3 = v5 * a;
    q = v3 / 32768;
    v4 = (q * q) / 128;
    v5 = v3 - (v4 * h1) / 16;
    if (v5 < 0) v5 = 0;
    if (v5 > 419430400) v5 = 419430400;
    v5 = v5 / 4096;
    if (v5 > 102400) v5 = 102400;
    return v5;
  endfunction

  function void note_input(logic [19:0] rp, logic [19:0] rt, logic [15:0] rh);
    comp_result_t res;
    int tf, t;
    t = calc_temp(int'(rt), tf);
    res.temp  = t[14:0];
    res.press = 17'(calc_press(int'(rp), tf));
    res.hum   = 17'(calc_hum(int'(rh), tf));
    pending_q.push_back(res);
  endfunction

  function void check_result(logic signed [14:0] t, logic [16:0] p, logic [16:0] h);
    comp_result_t exp_res;
    if (pending_q.size() == 0) begin
      $error("result beat with nothing pending");
      errors++;
      return;
    end
    exp_res = pending_q.pop_front();
    if (t !== exp_res.temp) begin
      $error("temperature_centi exp %0d got %0d", exp_res.temp, t);
      errors++;
    end
    if (p !== exp_res.press) begin
      $error("pressure_pa exp %0d got %0d", exp_res.press, p);
      errors++;
    end
    if (h !== exp_res.hum) begin
      $error("humidity_q10 exp %0d got %0d", exp_res.hum, h);
      errors++;
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import esc_pkg::*;

  localparam int LATENCY = 80;
  localparam longint CYCLE_LIMIT = 600000;

  logic clk, rst_n;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [63:0] pwdata, prdata;
  logic pready;
  longint cycles;
  comp_scoreboard sb;

  esc_in_if  in_ch ();
  esc_out_if out_ch ();

  env_sensor_compensation uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Pick a gap: mostly none or short, rarely long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sample results at the rising edge; drop ready at random
  int stall_left;
  bit no_stall;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.temperature_centi, out_ch.pressure_pa, out_ch.humidity_q10);
  end

  always @(negedge clk) begin
    if (!rst_n || no_stall) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      stall_left = gap_len();
      out_ch.ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 3'b000}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.calib[idx] = (idx == REG_HUM) ? val : {16'h0, val[47:0]};
  endtask

  // Hold a beat until accepted
  task automatic send_triple(logic [19:0] rp, logic [19:0] rt, logic [15:0] rh);
    in_ch.valid <= 1'b1;
    in_ch.raw_pressure <= rp;
    in_ch.raw_temperature <= rt;
    in_ch.raw_humidity <= rh;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(rp, rt, rh);
    @(negedge clk);
  endtask

  task automatic send_random(int n, bit gaps);
    int g;
    for (int i = 0; i < n; i++) begin
      send_triple(20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)),
                  16'($urandom_range(0, 16'hFFFF)));
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
        in_ch.valid <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  // Typical factory calibration, perturbed a little when jitter is set
  task automatic load_typical(bit jitter);
    logic [15:0] d;
    d = jitter ? 16'($urandom_range(0, 63)) : 16'd0;
    write_reg(REG_TEMP, {16'(50), 16'(26435 + d), 16'(27504 + d)});
    write_reg(REG_PRESS_A, {16'hF4A2 ^ d, 16'hD6D0 ^ d, 16'(36477 + d)});
    write_reg(REG_PRESS_B, {16'(-7), 16'(140 + d), 16'(2855 + d)});
    write_reg(REG_PRESS_C, {16'(6000 + d), 16'hC0C8 ^ d, 16'(15500)});
    write_reg(REG_HUM, {8'(30), 12'(50), 12'(330 + d), 8'(0), 16'(362), 8'(75)});
  endtask

  initial begin
    sb = new();
    cycles = 0;
    stall_left = 0;
    no_stall = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.raw_pressure = '0; in_ch.raw_temperature = '0; in_ch.raw_humidity = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // All-zero calibration: zero pressure divisor
    send_triple(20'h0, 20'h0, 16'h0);
    send_triple(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    in_ch.valid <= 1'b0;
    drain();

    // Directed extremes with typical calibration
    load_typical(1'b0);
    send_triple(20'd415148, 20'd519888, 16'd27000);
    send_triple(20'h0, 20'h0, 16'h0);
    send_triple(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_triple(20'hFFFFF, 20'h0, 16'h0);
    send_triple(20'h0, 20'hFFFFF, 16'hFFFF);
    send_triple(20'h80000, 20'h80000, 16'h8000);
    send_triple(20'h7FFFF, 20'h7FFFF, 16'h7FFF);
    send_triple(20'd300000, 20'd400000, 16'd40000);
    send_triple(20'd500000, 20'd600000, 16'd10000);
    in_ch.valid <= 1'b0;
    drain();

    // All-ones and sign-heavy calibration
    for (int k = 0; k < 5; k++) write_reg(3'(k), '1);
    send_triple(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_triple(20'h12345, 20'h6789A, 16'h5A5A);
    send_triple(20'h0, 20'h0, 16'h0);
    in_ch.valid <= 1'b0;
    drain();
    write_reg(REG_TEMP, {16'h8000, 16'h7FFF, 16'hFFFF});
    write_reg(REG_PRESS_A, {16'h7FFF, 16'h8000, 16'h0001});
    write_reg(REG_HUM, 64'h80FF_F000_FF80_00FF);
    send_triple(20'hFFFFF, 20'h0, 16'hFFFF);
    send_triple(20'h0, 20'hFFFFF, 16'h0);
    in_ch.valid <= 1'b0;
    drain();

    // Random phases: realistic calibration mostly, fully random sometimes
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 3 == 2) begin
        for (int k = 0; k < 5; k++) write_reg(3'(k), {$urandom(), $urandom()});
      end else begin
        load_typical(1'b1);
      end
      no_stall = (ph == 4);
      send_random(200, ph != 5);
      // Pause the sender until every result is back
      if (ph == 3) begin
        while (sb.pending_q.size() != 0) @(negedge clk);
        send_random(20, 1'b1);
      end
      drain();
    end
    no_stall = 1'b0;

    drain();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
